// ----- hdl/sobel_pkg.sv -----
package sobel_pkg;

    localparam int W_MAX      = 1024;
    localparam int H_MAX      = 4096;
    localparam int COL_W      = $clog2(W_MAX);
    localparam int WID_W      = 11;
    localparam int HGT_W      = 13;
    localparam int ROW_W      = HGT_W;
    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic [WID_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd480;

    // sum of squares at or above 255^2 rounds to at least 255
    localparam logic [20:0] SAT_LIMIT = 21'd65025;

    typedef struct packed {
        logic accept;
        logic read;
        logic shift;
        logic grad;
        logic square;
        logic root_step;
        logic round;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic produce;
        logic root_last;
        logic out_free;
    } dp_status_t;

endpackage

// ----- hdl/sobel_edge_magnitude_rgb.sv -----
// Sobel edge magnitude on an RGB pixel stream, three channels in parallel.
// Each item is read and shifted into the window; one that yields a beat goes on
// through gradients, squares, a per-channel square root (one result bit per
// cycle), round and emit, waiting for the output; only then is a new item taken.
// Reset (aresetn low, synchronous) restores 640x480, clears position, window
// and output valid; the line stores keep their contents.
module sobel_edge_magnitude_rgb import sobel_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // in_red, in_green, in_blue
    input  logic                  s_tuser,   // kind: pixel or flush
    // output beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIX_W-1:0]      m_tdata,   // out_red, out_green, out_blue
    output logic                  m_tlast
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequence each item: read lines, shift window, and for an item that yields
    // a beat gradients, squares, root, round, then hand it to the output register
    sobel_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // line stores, window, position counters and per-channel arithmetic
    sobel_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- hdl/sobel_ctrl.sv -----
module sobel_ctrl import sobel_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_READ   = 8'b0000_0010,
        ST_SHIFT  = 8'b0000_0100,
        ST_GRAD   = 8'b0000_1000,
        ST_SQUARE = 8'b0001_0000,
        ST_ROOT   = 8'b0010_0000,
        ST_ROUND  = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                cmd.shift  = 1'b1;
                state_next = status.produce ? ST_GRAD : ST_IDLE;
            end
            ST_GRAD: begin
                cmd.grad   = 1'b1;
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (status.root_last) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the output register can take the beat
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/sobel_dp.sv -----
module sobel_dp import sobel_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [PIX_W-1:0]      s_tdata,
    input  logic                  s_tuser,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIX_W-1:0]      m_tdata,
    output logic                  m_tlast
);

    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic [WID_W-1:0] eff_w;
    logic [HGT_W-1:0] eff_h;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [PIX_W-1:0] up_rd_reg, up2_rd_reg;
    logic [PIX_W-1:0] above, above2;
    logic [PIX_W-1:0] line0_mem [W_MAX];
    logic [PIX_W-1:0] line1_mem [W_MAX];
    logic [PIX_W-1:0] win_reg [3][3];
    logic             last_reg, ml_reg, mr_reg;
    logic [ROW_W-1:0] row_end;
    logic             produce, last, ml, mr;
    logic [WID_W-1:0] cc, col_inc;
    logic [2:0]       bit_idx_reg;
    logic             m_tvalid_reg, m_tlast_reg;
    logic [PIX_W-1:0] m_tdata_reg;
    logic [CH_W-1:0]  mag [NUM_CH];

    // clamp register values into the legal range
    assign eff_w = (width_reg == '0) ? WID_W'(1) :
                   (width_reg > WID_W'(W_MAX)) ? WID_W'(W_MAX) : width_reg;
    assign eff_h = (height_reg == '0) ? HGT_W'(1) :
                   (height_reg > HGT_W'(H_MAX)) ? HGT_W'(H_MAX) : height_reg;

    assign row_end = eff_h + ROW_W'(1);
    assign produce = (row_reg >= ROW_W'(2) || (row_reg == ROW_W'(1) && col_reg != '0))
                  && (row_reg < row_end || (row_reg == row_end && col_reg == '0));
    assign last    = (row_reg == row_end) && (col_reg == '0);
    assign cc      = (col_reg == '0) ? eff_w - WID_W'(1) : {1'b0, col_reg} - WID_W'(1);
    assign ml      = (cc == '0);
    assign mr      = (cc == eff_w - WID_W'(1));
    assign col_inc = {1'b0, col_reg} + WID_W'(1);

    assign above  = (row_reg >= ROW_W'(1)) ? up_rd_reg  : '0;
    assign above2 = (row_reg >= ROW_W'(2)) ? up2_rd_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (cfg_we) begin
            if (cfg_addr == REG_FRAME_WIDTH) begin
                width_reg <= cfg_wdata[WID_W-1:0];
            end else begin
                height_reg <= cfg_wdata[HGT_W-1:0];
            end
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.shift) begin
            if (row_reg >= row_end) begin
                col_reg <= '0;
                row_reg <= '0;
            end else if (col_inc >= eff_w) begin
                col_reg <= '0;
                row_reg <= row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_inc[COL_W-1:0];
            end
        end
    end

    // item capture; a flush inside the frame is black, a pixel after it is a flush
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pix_reg <= (s_tuser == KIND_PIXEL && row_reg < eff_h) ? s_tdata : '0;
        end
        if (cmd.shift) begin
            last_reg    <= last;
            ml_reg      <= ml;
            mr_reg      <= mr;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            up_rd_reg  <= line0_mem[col_reg];
            up2_rd_reg <= line1_mem[col_reg];
        end
        if (cmd.shift) begin
            line0_mem[col_reg] <= pix_reg;
            line1_mem[col_reg] <= above;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[k][j] <= '0;
                end
            end
        end else if (cmd.shift) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[k][0] <= win_reg[k][1];
                win_reg[k][1] <= win_reg[k][2];
            end
            win_reg[0][2] <= above2;
            win_reg[1][2] <= above;
            win_reg[2][2] <= pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.square) begin
            bit_idx_reg <= 3'd7;
        end else if (cmd.root_step) begin
            bit_idx_reg <= bit_idx_reg - 3'd1;
        end
    end

    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
        logic [CH_W-1:0]  p [3][3];
        logic [9:0]       xpos, xneg, ypos, yneg;
        logic [10:0]      gx, gy;
        logic [9:0]       ax_reg, ay_reg;
        logic [20:0]      sq;
        logic [15:0]      s_reg;
        logic             sat_reg;
        logic [CH_W-1:0]  root_reg, trial, mag_reg;
        logic [15:0]      trial_sq;
        logic [16:0]      round_lim;

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                p[k][0] = ml_reg ? '0 : win_reg[k][0][ch*CH_W +: CH_W];
                p[k][1] = win_reg[k][1][ch*CH_W +: CH_W];
                p[k][2] = mr_reg ? '0 : win_reg[k][2][ch*CH_W +: CH_W];
            end
        end

        assign xpos = 10'(p[0][2]) + {1'b0, p[1][2], 1'b0} + 10'(p[2][2]);
        assign xneg = 10'(p[0][0]) + {1'b0, p[1][0], 1'b0} + 10'(p[2][0]);
        assign ypos = 10'(p[2][0]) + {1'b0, p[2][1], 1'b0} + 10'(p[2][2]);
        assign yneg = 10'(p[0][0]) + {1'b0, p[0][1], 1'b0} + 10'(p[0][2]);
        assign gx   = {1'b0, xpos} - {1'b0, xneg};
        assign gy   = {1'b0, ypos} - {1'b0, yneg};

        assign sq        = 21'({10'b0, ax_reg} * {10'b0, ax_reg})
                         + 21'({10'b0, ay_reg} * {10'b0, ay_reg});
        assign trial     = root_reg | (CH_W'(1) << bit_idx_reg);
        assign trial_sq  = trial * trial;
        assign round_lim = 17'({8'b0, root_reg} * {8'b0, root_reg}) + 17'(root_reg);

        always_ff @(posedge aclk) begin
            if (cmd.grad) begin
                ax_reg <= gx[10] ? 10'(-gx) : gx[9:0];
                ay_reg <= gy[10] ? 10'(-gy) : gy[9:0];
            end
            if (cmd.square) begin
                s_reg    <= sq[15:0];
                sat_reg  <= (sq >= SAT_LIMIT);
                root_reg <= '0;
            end else if (cmd.root_step) begin
                // one result bit per step, most significant first
                if (trial_sq <= s_reg) begin
                    root_reg <= trial;
                end
            end
            if (cmd.round) begin
                if (sat_reg) begin
                    mag_reg <= '1;
                end else if ({1'b0, s_reg} > round_lim) begin
                    mag_reg <= root_reg + CH_W'(1);
                end else begin
                    mag_reg <= root_reg;
                end
            end
        end

        assign mag[ch] = mag_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {mag[2], mag[1], mag[0]};
            m_tlast_reg <= last_reg;
        end
    end

    assign status.produce   = produce;
    assign status.root_last = (bit_idx_reg == 3'd0);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- hdl/sobel_checker.sv -----
module sobel_checker import sobel_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [PIX_W-1:0] m_tdata,
    input logic             m_tlast
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // reset drops the output valid
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // one item at a time: busy right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // a result never appears the cycle after an accept
    a_no_fast_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("output beat too early");

endmodule

bind sobel_edge_magnitude_rgb sobel_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- sim/sobel_edge_magnitude_rgb_test.sv -----
module sobel_edge_magnitude_rgb_test;
    import sobel_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic            last;
    } edge_beat_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata;   // in_red, in_green, in_blue (red lowest)
    logic                  s_tuser;   // kind
    logic                  m_tvalid;
    logic                  m_tready;
    logic [PIX_W-1:0]      m_tdata;   // out_red, out_green, out_blue (red lowest)
    logic                  m_tlast;

    sobel_edge_magnitude_rgb uut (.*);

    // predictor state
    logic [10:0]      width_reg;
    logic [12:0]      height_reg;
    logic [PIX_W-1:0] line_prev [W_MAX];
    logic [PIX_W-1:0] line_prev2[W_MAX];
    logic [PIX_W-1:0] win[3][3];
    int unsigned      col_pos, row_pos;

    edge_beat_t edge_queue[$];
    int         fail_count;
    int         beats_seen;
    int         burst_left;
    int         items_sent;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop if the pipeline hangs
    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned cur_width();
        if (width_reg == 0) return 1;
        if (width_reg > W_MAX) return W_MAX;
        return width_reg;
    endfunction

    function automatic int unsigned cur_height();
        if (height_reg == 0) return 1;
        if (height_reg > H_MAX) return H_MAX;
        return height_reg;
    endfunction

    // rounded, clamped gradient magnitude of one channel
    function automatic logic [7:0] chan_magnitude(bit ml, bit mr, int sh);
        int p[3][3];
        int gx, gy;
        longint s, n;
        for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++)
                p[k][j] = (win[k][j] >> sh) & 8'hff;
        if (ml) begin
            p[0][0] = 0; p[1][0] = 0; p[2][0] = 0;
        end
        if (mr) begin
            p[0][2] = 0; p[1][2] = 0; p[2][2] = 0;
        end
        gx = (p[0][2] + 2*p[1][2] + p[2][2]) - (p[0][0] + 2*p[1][0] + p[2][0]);
        gy = (p[2][0] + 2*p[2][1] + p[2][2]) - (p[0][0] + 2*p[0][1] + p[0][2]);
        s = gx*gx + gy*gy;
        n = 0;
        while ((n+1)*(n+1) <= s) n++;
        if (s > n*n + n) n++;
        return (n > 255) ? 8'd255 : n[7:0];
    endfunction

    // advance the predictor by one accepted beat
    task automatic predict_edge(bit kind, logic [PIX_W-1:0] pix);
        int unsigned w, total, t, cc;
        logic [PIX_W-1:0] data, above, above2;
        edge_beat_t b;
        w = cur_width();
        total = w * cur_height();
        t = row_pos * w + col_pos;
        data = (kind == KIND_PIXEL && t < total) ? pix : '0;
        above  = (row_pos >= 1) ? line_prev[col_pos]  : '0;
        above2 = (row_pos >= 2) ? line_prev2[col_pos] : '0;
        line_prev2[col_pos] = above;
        line_prev[col_pos]  = data;
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = above2;
        win[1][2] = above;
        win[2][2] = data;
        if (t >= w + 1 && t <= total + w) begin
            cc = (col_pos == 0) ? w - 1 : col_pos - 1;
            b.red   = chan_magnitude(cc == 0, cc == w - 1, 0);
            b.green = chan_magnitude(cc == 0, cc == w - 1, 8);
            b.blue  = chan_magnitude(cc == 0, cc == w - 1, 16);
            b.last  = (t == total + w);
            edge_queue.push_back(b);
        end
        if (t >= total + w) begin
            col_pos = 0; row_pos = 0;
        end else begin
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0; row_pos++;
            end
        end
    endtask

    // send one beat; the sender runs in bursts with random gaps
    task automatic send_beat(bit kind, logic [PIX_W-1:0] pix);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        items_sent++;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        predict_edge(kind, pix);
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (edge_queue.size() != 0) @(posedge aclk);
        // items that yield nothing may still be in flight
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        go_idle();
        cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_FRAME_WIDTH) width_reg = val[10:0];
        else height_reg = val[12:0];
        col_pos = 0; row_pos = 0;
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return {$urandom_range(0, 1) ? 8'hff : 8'h00, 8'h00,
                       $urandom_range(0, 1) ? 8'hff : 8'h00};
            default: return PIX_W'($urandom());
        endcase
    endfunction

    // whole frame: pixels, then flushes until the last beat comes out; noise_pct swaps the kind of some beats
    task automatic send_frame(int noise_pct);
        int unsigned w, total;
        w = cur_width();
        total = w * cur_height();
        for (int unsigned i = 0; i < total + w + 1; i++) begin
            if (i < total)
                send_beat(($urandom_range(0, 99) < noise_pct) ? KIND_FLUSH : KIND_PIXEL,
                          rand_pixel());
            else
                send_beat(($urandom_range(0, 99) < noise_pct) ? KIND_PIXEL : KIND_FLUSH,
                          rand_pixel());
        end
    endtask

    // directed: extremes, flush inside frame, pixel after frame, clamping
    task automatic test_directed();
        write_reg(REG_FRAME_WIDTH, 13'd3);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        send_beat(KIND_PIXEL, 24'hffffff);
        send_beat(KIND_PIXEL, 24'h000000);
        send_beat(KIND_PIXEL, 24'hffffff);
        send_beat(KIND_FLUSH, 24'h123456);
        send_beat(KIND_PIXEL, 24'hff00ff);
        send_beat(KIND_PIXEL, 24'h00ff00);
        send_beat(KIND_PIXEL, 24'hffffff);
        send_beat(KIND_PIXEL, 24'h000000);
        send_beat(KIND_PIXEL, 24'haa55aa);
        for (int i = 0; i < 4; i++) send_beat(KIND_PIXEL, 24'hffffff);
    endtask

    // single pixel frames, zero registers used as one, then a one-column frame
    task automatic test_tiny_frames();
        write_reg(REG_FRAME_WIDTH, 13'd0);
        write_reg(REG_FRAME_HEIGHT, 13'd0);
        repeat (3) send_frame(20);
        write_reg(REG_FRAME_WIDTH, 13'd1);
        write_reg(REG_FRAME_HEIGHT, 13'd5);
        send_frame(10);
    endtask

    // oversize registers clamp to the maxima; only a partial frame is sent
    task automatic test_max_width();
        write_reg(REG_FRAME_WIDTH, 13'h7ff);
        write_reg(REG_FRAME_HEIGHT, 13'h1fff);
        repeat (300) send_beat(KIND_PIXEL, rand_pixel());
    endtask

    task automatic test_random_frames();
        while (items_sent < 600) begin
            write_reg(REG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(1, 12)));
            write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(1, 8)));
            send_frame($urandom_range(0, 1) ? 0 : 8);
        end
        // abandon a frame midway, then restart after a register write
        write_reg(REG_FRAME_WIDTH, 13'd4);
        repeat (9) send_beat(KIND_PIXEL, rand_pixel());
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        send_frame(0);
    endtask

    // receiver: stall pattern of its own, with long stall-free stretches
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else if ((beats_seen / 64) % 3 == 0) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    // compare each output beat with the oldest prediction
    always @(posedge aclk) begin
        edge_beat_t exp_b, act_b;
        if (aresetn && m_tvalid && m_tready) begin
            beats_seen++;
            act_b = {m_tdata, m_tlast};
            if (edge_queue.size() == 0) begin
                $display("%0t: unexpected beat %h", $time, act_b);
                fail_count++;
            end else begin
                exp_b = edge_queue.pop_front();
                if (exp_b.red !== act_b.red) begin
                    $display("%0t: red expected %h actual %h", $time, exp_b.red, act_b.red);
                    fail_count++;
                end
                if (exp_b.green !== act_b.green) begin
                    $display("%0t: green expected %h actual %h", $time,
                             exp_b.green, act_b.green);
                    fail_count++;
                end
                if (exp_b.blue !== act_b.blue) begin
                    $display("%0t: blue expected %h actual %h", $time,
                             exp_b.blue, act_b.blue);
                    fail_count++;
                end
                if (exp_b.last !== act_b.last) begin
                    $display("%0t: last expected %b actual %b", $time,
                             exp_b.last, act_b.last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        fail_count = 0; beats_seen = 0; burst_left = 0; items_sent = 0;
        width_reg = WIDTH_RESET; height_reg = HEIGHT_RESET;
        col_pos = 0; row_pos = 0;
        for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++) win[k][j] = '0;
        foreach (line_prev[i]) begin
            line_prev[i] = '0; line_prev2[i] = '0;
        end
        aresetn = 1'b0; cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = KIND_PIXEL;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_tiny_frames();
        test_max_width();
        test_random_frames();
        go_idle();
        if (fail_count == 0 && edge_queue.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
